// ----- rtl/core/jfhs_pkg.sv -----
// ----------------------------------------------------------------------------
// jfhs_pkg: shared types and constants for the JPEG frame header scanner
// Parse phases, result status codes and the marker codes the scanner decodes.
// ----------------------------------------------------------------------------
package jfhs_pkg;

    // Parse phase, one-hot
    typedef enum logic [8:0] {
        PH_START0 = 9'b000000001,
        PH_START1 = 9'b000000010,
        PH_SCAN   = 9'b000000100,
        PH_MARKER = 9'b000001000,
        PH_LEN_HI = 9'b000010000,
        PH_LEN_LO = 9'b000100000,
        PH_SKIP   = 9'b001000000,
        PH_SOF    = 9'b010000000,
        PH_DONE   = 9'b100000000
    } phase_t;

    // Result status codes
    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NO_SOI    = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_ZERO_DIM  = 2'd3;

    // Marker codes
    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_SOI    = 8'hD8;
    localparam logic [7:0] MARKER_SOF0   = 8'hC0;
    localparam logic [7:0] MARKER_SOF2   = 8'hC2;
    localparam logic [7:0] MARKER_SOS    = 8'hDA;
    localparam logic [7:0] MARKER_STUFF  = 8'h00;
    localparam logic [7:0] MARKER_TEM    = 8'h01;
    localparam logic [7:0] MARKER_RST0   = 8'hD0;
    localparam logic [7:0] MARKER_EOI    = 8'hD9;

    // Frame header byte offsets after the SOF marker
    localparam logic [15:0] SOF_OFS_HEIGHT_HI = 16'd3;
    localparam logic [15:0] SOF_OFS_HEIGHT_LO = 16'd4;
    localparam logic [15:0] SOF_OFS_WIDTH_HI  = 16'd5;
    localparam logic [15:0] SOF_OFS_WIDTH_LO  = 16'd6;
    localparam logic [15:0] SOF_OFS_COUNT     = 16'd7;

endpackage

// ----- rtl/core/jpeg_frame_header_scanner.sv -----
// ----------------------------------------------------------------------------
// jpeg_frame_header_scanner: JPEG marker walker that extracts SOF dimensions
// Takes a JPEG file one byte per word and gives one status word per file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one file byte per word, s_last_byte set on the final
//   byte of a file. The next word after a final byte starts a new file.
//   Result channel (m_*): exactly one word per file: status, height, width
//   and component count. Status is found, no start marker, frame header not
//   found, or zero dimension; the size fields are zero unless found.
//   Throughput: one byte per clock while s_ready is high. Each byte is
//   decoded by the phase state machine in the cycle it is accepted; a
//   result goes into the output register (or the skid entry while that is
//   still held) at the edge that accepts the deciding byte.
//   The result side has an output register plus one skid entry. When the
//   receiver stalls, input keeps flowing until a second result is pending in
//   the skid entry; s_ready then drops until the output register drains.
//   Bytes after a result are consumed without output until the final byte.
//   Reset (aresetn low, synchronous) returns the parser to the start of a
//   file and empties both result entries; no clearing pass is needed.
// ----------------------------------------------------------------------------
module jpeg_frame_header_scanner
    import jfhs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_image_height,
    output logic [15:0] m_image_width,
    output logic [7:0]  m_component_count
);

    // Parser state
    phase_t      phase_reg,  phase_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg,  width_next;

    // Result produced by the current byte
    logic        res_valid;
    logic [1:0]  res_status;
    logic [15:0] res_height;
    logic [15:0] res_width;
    logic [7:0]  res_count;

    // Output register and skid entry
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [15:0] out_height_reg;
    logic [15:0] out_width_reg;
    logic [7:0]  out_count_reg;
    logic        skid_valid_reg;
    logic [1:0]  skid_status_reg;
    logic [15:0] skid_height_reg;
    logic [15:0] skid_width_reg;
    logic [7:0]  skid_count_reg;

    logic        accept;
    logic        pop;
    logic        push;
    logic        skip_end;
    logic        no_len_marker;
    logic [15:0] offset_inc;
    logic [15:0] len_full;

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign pop      = out_valid_reg && m_ready;
    assign push     = accept && res_valid;

    assign offset_inc = offset_reg + 16'd1;
    // Segment body done once the count reaches length minus the length field
    assign skip_end   = offset_inc >= (length_reg - 16'd2);
    assign len_full   = {length_reg[15:8], s_data_byte};

    // Stuffed byte, TEM and RSTn/SOI/EOI carry no length
    assign no_len_marker = (s_data_byte inside {MARKER_STUFF, MARKER_TEM,
                                                [MARKER_RST0:MARKER_EOI]});

    // ------------------------------------------------------------------
    // Byte decode
    // ------------------------------------------------------------------
    always_comb begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        length_next = length_reg;
        height_next = height_reg;
        width_next  = width_reg;
        res_valid   = 1'b0;
        res_status  = STATUS_FOUND;
        res_height  = '0;
        res_width   = '0;
        res_count   = '0;

        if (accept) begin
            unique case (phase_reg)
                PH_START0: begin
                    if (s_data_byte == MARKER_PREFIX) begin
                        phase_next = PH_START1;
                    end else begin
                        res_valid  = 1'b1;
                        res_status = STATUS_NO_SOI;
                        phase_next = PH_DONE;
                    end
                end
                PH_START1: begin
                    if (s_data_byte == MARKER_SOI) begin
                        phase_next = PH_SCAN;
                    end else begin
                        res_valid  = 1'b1;
                        res_status = STATUS_NO_SOI;
                        phase_next = PH_DONE;
                    end
                end
                PH_SCAN: begin
                    if (s_data_byte == MARKER_PREFIX) begin
                        phase_next = PH_MARKER;
                    end
                end
                PH_MARKER: begin
                    // FF padding keeps us here
                    if (s_data_byte == MARKER_PREFIX) begin
                        phase_next = PH_MARKER;
                    end else if (s_data_byte == MARKER_SOF0 ||
                                 s_data_byte == MARKER_SOF2) begin
                        phase_next  = PH_SOF;
                        offset_next = '0;
                    end else if (s_data_byte == MARKER_SOS) begin
                        res_valid  = 1'b1;
                        res_status = STATUS_NOT_FOUND;
                        phase_next = PH_DONE;
                    end else if (no_len_marker) begin
                        phase_next = PH_SCAN;
                    end else begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    length_next = {s_data_byte, 8'h00};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    length_next = len_full;
                    if (len_full < 16'd2) begin
                        res_valid  = 1'b1;
                        res_status = STATUS_NOT_FOUND;
                        phase_next = PH_DONE;
                    end else if (len_full == 16'd2) begin
                        phase_next = PH_SCAN;
                    end else begin
                        offset_next = '0;
                        phase_next  = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    offset_next = offset_inc;
                    if (skip_end) begin
                        phase_next = PH_SCAN;
                    end
                end
                PH_SOF: begin
                    case (offset_reg)
                        SOF_OFS_HEIGHT_HI: height_next = {s_data_byte, 8'h00};
                        SOF_OFS_HEIGHT_LO: height_next = {height_reg[15:8], s_data_byte};
                        SOF_OFS_WIDTH_HI:  width_next  = {s_data_byte, 8'h00};
                        SOF_OFS_WIDTH_LO:  width_next  = {width_reg[15:8], s_data_byte};
                        default: ;
                    endcase
                    if (offset_reg >= SOF_OFS_COUNT) begin
                        res_valid  = 1'b1;
                        phase_next = PH_DONE;
                        if (height_reg == '0 || width_reg == '0) begin
                            res_status = STATUS_ZERO_DIM;
                        end else begin
                            res_status = STATUS_FOUND;
                            res_height = height_reg;
                            res_width  = width_reg;
                            res_count  = s_data_byte;
                        end
                    end else begin
                        offset_next = offset_inc;
                    end
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_START0;
                end
            endcase

            // End of file: report if nothing was given, then restart
            if (s_last_byte) begin
                if (phase_next != PH_DONE) begin
                    res_valid  = 1'b1;
                    res_status = (phase_next == PH_START1) ? STATUS_NO_SOI
                                                           : STATUS_NOT_FOUND;
                    res_height = '0;
                    res_width  = '0;
                    res_count  = '0;
                end
                phase_next = PH_START0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START0;
        end else begin
            phase_reg <= phase_next;
        end
        offset_reg <= offset_next;
        length_reg <= length_next;
        height_reg <= height_next;
        width_reg  <= width_next;
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_status_reg <= skid_status_reg;
                out_height_reg <= skid_height_reg;
                out_width_reg  <= skid_width_reg;
                out_count_reg  <= skid_count_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_status_reg <= res_status;
                out_height_reg <= res_height;
                out_width_reg  <= res_width;
                out_count_reg  <= res_count;
            end else begin
                skid_status_reg <= res_status;
                skid_height_reg <= res_height;
                skid_width_reg  <= res_width;
                skid_count_reg  <= res_count;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = out_status_reg;
    assign m_image_height    = out_height_reg;
    assign m_image_width     = out_width_reg;
    assign m_component_count = out_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Skid entry is only filled behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while output register is empty");

    // A final byte always returns the parser to the start of a file
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_byte) |=> (phase_reg == PH_START0))
        else $error("parser not restarted after final byte");

    // Once a result is given, no other is produced until the final byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_DONE) |-> !res_valid)
        else $error("second result within one file");

    // Size fields are only nonzero on a found result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_FOUND) |->
            (m_image_height == '0 && m_image_width == '0 && m_component_count == '0))
        else $error("size fields nonzero on a failed result");

endmodule

// ----- sim/jfhs_checker.sv -----
// ----------------------------------------------------------------------------
// jfhs_checker: result predictor and comparator for the frame header scanner
// Watches both channels, rebuilds the expected status word of every file
// from the accepted bytes, and compares each result word field by field.
// ----------------------------------------------------------------------------
module jfhs_checker
    import jfhs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [15:0] m_image_height,
    input  logic [15:0] m_image_width,
    input  logic [7:0]  m_component_count,

    input  logic        end_check,
    output int          fail_count,
    output int          open_count
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] height;
        logic [15:0] width;
        logic [7:0]  count;
    } frame_info_t;

    frame_info_t frames_due[$];

    // Predictor state
    phase_t      scan_phase;
    logic [15:0] seg_ofs;
    logic [15:0] seg_len;
    logic [15:0] hold_height;
    logic [15:0] hold_width;
    logic        file_done;

    int mismatches = 0;
    bit end_seen   = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task automatic restart_file();
        scan_phase  = PH_START0;
        seg_ofs     = '0;
        seg_len     = '0;
        hold_height = '0;
        hold_width  = '0;
        file_done   = 1'b0;
    endtask

    task automatic post_frame(input logic [1:0] st, input logic [15:0] h,
                              input logic [15:0] w, input logic [7:0] c);
        frames_due.push_back('{status: st, height: h, width: w, count: c});
        file_done  = 1'b1;
        scan_phase = PH_DONE;
    endtask

    // One accepted file byte through the marker walk
    task automatic scan_byte(input logic [7:0] b, input logic last);
        case (scan_phase)
            PH_START0: begin
                if (b == MARKER_PREFIX) scan_phase = PH_START1;
                else post_frame(STATUS_NO_SOI, '0, '0, '0);
            end
            PH_START1: begin
                if (b == MARKER_SOI) scan_phase = PH_SCAN;
                else post_frame(STATUS_NO_SOI, '0, '0, '0);
            end
            PH_SCAN: begin
                if (b == MARKER_PREFIX) scan_phase = PH_MARKER;
            end
            PH_MARKER: begin
                if (b == MARKER_PREFIX) begin
                    // fill byte, stay
                end else if (b == MARKER_SOF0 || b == MARKER_SOF2) begin
                    scan_phase = PH_SOF;
                    seg_ofs    = '0;
                end else if (b == MARKER_SOS) begin
                    post_frame(STATUS_NOT_FOUND, '0, '0, '0);
                end else if (b == MARKER_STUFF || b == MARKER_TEM ||
                             (b >= MARKER_RST0 && b <= MARKER_EOI)) begin
                    scan_phase = PH_SCAN;
                end else begin
                    scan_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                seg_len    = {b, 8'h00};
                scan_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seg_len = seg_len | {8'h00, b};
                if (seg_len < 16'd2) begin
                    post_frame(STATUS_NOT_FOUND, '0, '0, '0);
                end else if (seg_len == 16'd2) begin
                    scan_phase = PH_SCAN;
                end else begin
                    seg_ofs    = '0;
                    scan_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                seg_ofs = seg_ofs + 16'd1;
                if (seg_ofs >= seg_len - 16'd2) scan_phase = PH_SCAN;
            end
            PH_SOF: begin
                case (seg_ofs)
                    SOF_OFS_HEIGHT_HI: hold_height = {b, 8'h00};
                    SOF_OFS_HEIGHT_LO: hold_height = hold_height | {8'h00, b};
                    SOF_OFS_WIDTH_HI:  hold_width  = {b, 8'h00};
                    SOF_OFS_WIDTH_LO:  hold_width  = hold_width | {8'h00, b};
                    default: ;
                endcase
                if (seg_ofs >= SOF_OFS_COUNT) begin
                    if (hold_height == '0 || hold_width == '0)
                        post_frame(STATUS_ZERO_DIM, '0, '0, '0);
                    else
                        post_frame(STATUS_FOUND, hold_height, hold_width, b);
                end else begin
                    seg_ofs = seg_ofs + 16'd1;
                end
            end
            default: ;
        endcase

        // final byte: close the file if nothing was reported yet
        if (last) begin
            if (!file_done) begin
                if (scan_phase == PH_START0 || scan_phase == PH_START1)
                    post_frame(STATUS_NO_SOI, '0, '0, '0);
                else
                    post_frame(STATUS_NOT_FOUND, '0, '0, '0);
            end
            restart_file();
        end
    endtask

    task automatic compare_frame();
        frame_info_t want;
        if (frames_due.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected: st=%0d h=%0d w=%0d c=%0d",
                                      m_status, m_image_height, m_image_width,
                                      m_component_count));
        end else begin
            want = frames_due.pop_front();
            if (m_status != want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          m_status, want.status));
            if (m_image_height != want.height)
                report_mismatch($sformatf("height %0d, expected %0d",
                                          m_image_height, want.height));
            if (m_image_width != want.width)
                report_mismatch($sformatf("width %0d, expected %0d",
                                          m_image_width, want.width));
            if (m_component_count != want.count)
                report_mismatch($sformatf("component count %0d, expected %0d",
                                          m_component_count, want.count));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_file();
            frames_due.delete();
        end else begin
            if (m_valid && m_ready) compare_frame();
            if (s_valid && s_ready) scan_byte(s_data_byte, s_last_byte);
            if (end_check && !end_seen) begin
                end_seen = 1'b1;
                if (frames_due.size() != 0)
                    report_mismatch($sformatf("%0d expected result words never arrived",
                                              frames_due.size()));
            end
        end
        fail_count <= mismatches;
        open_count <= frames_due.size();
    end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top for the JPEG frame header scanner
// Feeds directed and random JPEG-like files byte by byte with random gaps
// and receiver stalls; the checker predicts and compares every status word.
// ----------------------------------------------------------------------------
module tb
    import jfhs_pkg::*;
();

    localparam int BYTE_TARGET  = 2000;   // random part stops past this count
    localparam int STALL_LIMIT  = 4000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int HOLD_AT_WORD = 12;     // result word that starts the hold-off
    localparam int IDLE_PCT     = 26;

    // APPn markers: plain length-prefixed segments
    localparam logic [7:0] MARKER_APP0 = 8'hE0;
    localparam logic [7:0] MARKER_APP1 = 8'hE1;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_image_height;
    logic [15:0] m_image_width;
    logic [7:0]  m_component_count;

    logic        end_check   = 1'b0;
    logic        steady      = 1'b0;  // no-idle stretch on both sides
    int          fail_count;
    int          open_count;
    int          bytes_sent  = 0;

    logic [7:0]  file_q[$];           // bytes of the file being sent

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    jpeg_frame_header_scanner dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_image_height    (m_image_height),
        .m_image_width     (m_image_width),
        .m_component_count (m_component_count)
    );

    jfhs_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_image_height    (m_image_height),
        .m_image_width     (m_image_width),
        .m_component_count (m_component_count),
        .end_check         (end_check),
        .fail_count        (fail_count),
        .open_count        (open_count)
    );

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // One word on the input channel. Random idle cycles go in front of it;
    // valid is only dropped in a step where it is not raised again.
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (!steady && $urandom_range(99) < IDLE_PCT) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        steady <= (bytes_sent >= 800 && bytes_sent < 1200);
    endtask

    // Whole file_q, last flag on its final byte
    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            push_byte(file_q[i], i == file_q.size() - 1);
    endtask

    // A marker code that carries a plain length field
    function automatic logic [7:0] plain_marker();
        logic [7:0] mk;
        do begin
            mk = 8'($urandom_range(255));
        end while (mk == MARKER_PREFIX || mk == MARKER_SOF0 || mk == MARKER_SOF2 ||
                   mk == MARKER_SOS || mk == MARKER_STUFF || mk == MARKER_TEM ||
                   (mk >= MARKER_RST0 && mk <= MARKER_EOI));
        return mk;
    endfunction

    // Mostly well-formed files with random content, plus noise, broken
    // start markers and files cut off at a random byte.
    task automatic build_random_file();
        int          kind;
        int          seg_len;
        int          code;
        int          cut;
        logic [15:0] dim_h;
        logic [15:0] dim_w;
        file_q.delete();
        kind = $urandom_range(99);
        if (kind < 12) begin
            // pure noise
            repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom_range(255)));
        end else begin
            file_q.push_back(MARKER_PREFIX);
            file_q.push_back(MARKER_SOI);
            if (kind < 18) file_q[$urandom_range(1)] = 8'($urandom_range(255));
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(3))
                    0: begin
                        // stray data between segments
                        repeat ($urandom_range(1, 3))
                            file_q.push_back(8'($urandom_range(254)));
                    end
                    1, 3: begin
                        // optional fill bytes, then a standalone marker
                        repeat ($urandom_range(1, 3)) file_q.push_back(MARKER_PREFIX);
                        code = $urandom_range(11);
                        if (code == 0)      file_q.push_back(MARKER_STUFF);
                        else if (code == 1) file_q.push_back(MARKER_TEM);
                        else                file_q.push_back(MARKER_RST0 + 8'(code - 2));
                    end
                    default: begin
                        // length-prefixed segment, rarely a long one
                        file_q.push_back(MARKER_PREFIX);
                        file_q.push_back(plain_marker());
                        if ($urandom_range(19) == 0) seg_len = $urandom_range(200, 400);
                        else                         seg_len = $urandom_range(2, 10);
                        file_q.push_back(seg_len[15:8]);
                        file_q.push_back(seg_len[7:0]);
                        repeat (seg_len - 2) file_q.push_back(8'($urandom_range(255)));
                    end
                endcase
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    // frame header, with zero and full-scale sizes now and then
                    case ($urandom_range(7))
                        0:       dim_h = '0;
                        1:       dim_h = 16'hFFFF;
                        default: dim_h = 16'($urandom_range(1, 65535));
                    endcase
                    case ($urandom_range(7))
                        0:       dim_w = '0;
                        1:       dim_w = 16'hFFFF;
                        default: dim_w = 16'($urandom_range(1, 65535));
                    endcase
                    file_q.push_back(MARKER_PREFIX);
                    file_q.push_back($urandom_range(1) ? MARKER_SOF2 : MARKER_SOF0);
                    repeat (3) file_q.push_back(8'($urandom_range(255)));
                    file_q.push_back(dim_h[15:8]);
                    file_q.push_back(dim_h[7:0]);
                    file_q.push_back(dim_w[15:8]);
                    file_q.push_back(dim_w[7:0]);
                    file_q.push_back(8'($urandom_range(255)));
                end
                6: begin
                    file_q.push_back(MARKER_PREFIX);
                    file_q.push_back(MARKER_SOS);
                end
                7: begin
                    // segment length below two
                    file_q.push_back(MARKER_PREFIX);
                    file_q.push_back(plain_marker());
                    file_q.push_back(8'h00);
                    file_q.push_back(8'($urandom_range(1)));
                end
                default: ;  // no frame header at all
            endcase
            repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom_range(255)));
            if ($urandom_range(9) == 0) begin
                cut = $urandom_range(1, file_q.size());
                while (file_q.size() > cut) void'(file_q.pop_back());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, one long hold-off that backs up the block
    // ------------------------------------------------------------------------
    initial begin
        int words_seen;
        int hold_left;
        bit held;
        words_seen = 0;
        hold_left  = 0;
        held       = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) words_seen++;
            if (words_seen == HOLD_AT_WORD && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("** jpeg_frame_header_scanner: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // bad first byte
        file_q = '{8'h00};
        send_file();
        // bad second byte
        file_q = '{MARKER_PREFIX, MARKER_STUFF};
        send_file();
        // file ends inside the start marker
        file_q = '{MARKER_PREFIX};
        send_file();
        // fill bytes, standalone markers, then a length below two
        file_q = '{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_PREFIX, MARKER_TEM,
                   MARKER_PREFIX, MARKER_RST0, MARKER_PREFIX, MARKER_APP0, 8'h00, 8'h01};
        send_file();
        // start of scan stops the search; trailing byte ignored
        file_q = '{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_SOS, 8'h77};
        send_file();
        // zero height, then a byte after the result
        file_q = '{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_SOF0, 8'h00, 8'h11,
                   8'h08, 8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h5A};
        send_file();
        // stray data, end-of-image marker passed over, full-scale progressive header
        file_q = '{MARKER_PREFIX, MARKER_SOI, 8'h12, MARKER_PREFIX, MARKER_EOI,
                   MARKER_PREFIX, MARKER_SOF2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF};
        send_file();
        // file ends right after a skipped segment
        file_q = '{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_APP1, 8'h00, 8'h03,
                   8'hAB};
        send_file();

        while (bytes_sent < BYTE_TARGET) begin
            build_random_file();
            send_file();
        end
        s_valid <= 1'b0;

        // drain: every expected word in, then a short settle
        @(posedge aclk);
        while (open_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        end_check <= 1'b1;
        repeat (2) @(posedge aclk);

        if (fail_count == 0) begin
            $display("** jpeg_frame_header_scanner: PASSED **");
        end else begin
            $display("** jpeg_frame_header_scanner: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/jfhs_pkg.sv
rtl/core/jpeg_frame_header_scanner.sv
sim/jfhs_checker.sv
sim/tb.sv
